### sv/bcv_pkg.sv
// ----------------------------------------------------------------------------
// bcv_pkg
// Shared types and constants of the two-sided block convolution filter.
// ----------------------------------------------------------------------------
package bcv_pkg;

  localparam int NUM_CAUSAL = 16;
  localparam int NUM_ANTI   = 16;
  localparam int NUM_CELLS  = NUM_CAUSAL + NUM_ANTI;
  localparam int SAMPLE_W   = 16;
  localparam int FRAC_W     = 15;
  localparam int PROD_W     = 2 * SAMPLE_W;
  localparam int OUT_W      = 32;
  localparam int CNT_W      = 5;
  localparam int TAP_W      = 4;
  localparam int CFG_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam logic [CNT_W-1:0] SEEN_LIMIT = CNT_W'(NUM_ANTI + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]   prod_t;

  typedef enum logic [1:0] {
    KIND_SAMPLE,
    KIND_CAUSAL,
    KIND_ANTI,
    KIND_NONE
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAUSAL_USED,
    REG_ANTI_USED,
    REG_SYMMETRIC,
    REG_NONE
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_PRESHIFT,
    S_START,
    S_WAIT,
    S_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

### sv/bcv_if.sv
// ----------------------------------------------------------------------------
// bcv_in_if / bcv_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface bcv_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           kind;
  logic [bcv_pkg::TAP_W-1:0]            tap_index;
  logic signed [bcv_pkg::SAMPLE_W-1:0]  value;
  logic                                 block_end;
  modport source (output valid, kind, tap_index, value, block_end, input ready);
  modport sink (input valid, kind, tap_index, value, block_end, output ready);
endinterface

interface bcv_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [bcv_pkg::OUT_W-1:0]  filtered;
  logic                              final_output;
  modport source (output valid, filtered, final_output, input ready);
  modport sink (input valid, filtered, final_output, output ready);
endinterface

### sv/bcv_cell.sv
// ----------------------------------------------------------------------------
// bcv_cell
// One tap cell: holds a sample, passes it to its neighbor, registers a product.
// ----------------------------------------------------------------------------
module bcv_cell (
  input  logic                 clk_i,
  input  bcv_pkg::cell_ctrl_t  ctrl_i,
  input  bcv_pkg::sample_t     load_val_i,
  input  bcv_pkg::sample_t     prev_i,
  input  bcv_pkg::sample_t     coef_i,
  input  logic                 use_i,
  output bcv_pkg::sample_t     sample_o,
  output bcv_pkg::prod_t       prod_o
);

  bcv_pkg::sample_t sample_q;
  bcv_pkg::prod_t   prod_q;
  bcv_pkg::prod_t   prod_d;

  assign prod_d = use_i ? bcv_pkg::prod_t'(sample_q) * bcv_pkg::prod_t'(coef_i) : '0;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      sample_q <= load_val_i;
    end else if (ctrl_i.shift) begin
      sample_q <= prev_i;
    end
    prod_q <= prod_d;
  end

  assign sample_o = sample_q;
  assign prod_o   = prod_q;

endmodule

### sv/bcv_sum.sv
// ----------------------------------------------------------------------------
// bcv_sum
// Registered adder tree over the cell products with rounding shift.
// ----------------------------------------------------------------------------
module bcv_sum (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  bcv_pkg::prod_t                    prod_i [bcv_pkg::NUM_CELLS],
  output logic                              valid_o,
  output logic signed [bcv_pkg::OUT_W-1:0]  result_o
);

  localparam int S1_N = bcv_pkg::NUM_CELLS / 4;
  localparam int S2_N = S1_N / 4;
  localparam int S1_W = bcv_pkg::PROD_W + 2;
  localparam int S2_W = S1_W + 2;
  localparam int S3_W = S2_W + 1;

  logic signed [S1_W-1:0] s1_d [S1_N];
  logic signed [S1_W-1:0] s1_q [S1_N];
  logic signed [S2_W-1:0] s2_d [S2_N];
  logic signed [S2_W-1:0] s2_q [S2_N];
  logic signed [S3_W-1:0] total;
  logic signed [bcv_pkg::OUT_W-1:0] result_d;
  logic signed [bcv_pkg::OUT_W-1:0] result_q;
  logic [3:0] vld_q;

  always_comb begin
    for (int g = 0; g < S1_N; g++) begin
      s1_d[g] = '0;
      for (int j = 0; j < 4; j++) begin
        s1_d[g] = s1_d[g] + S1_W'(prod_i[4*g+j]);
      end
    end
    for (int g = 0; g < S2_N; g++) begin
      s2_d[g] = '0;
      for (int j = 0; j < 4; j++) begin
        s2_d[g] = s2_d[g] + S2_W'(s1_q[4*g+j]);
      end
    end
    total = S3_W'(s2_q[0]) + S3_W'(s2_q[1]) + S3_W'(1 << (bcv_pkg::FRAC_W - 1));
    result_d = bcv_pkg::OUT_W'(total >>> bcv_pkg::FRAC_W);
  end

  always_ff @(posedge clk_i) begin
    s1_q     <= s1_d;
    s2_q     <= s2_d;
    result_q <= result_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], start_i};
    end
  end

  assign valid_o  = vld_q[3];
  assign result_o = result_q;

endmodule

### sv/two_sided_block_convolution.sv
// ----------------------------------------------------------------------------
// two_sided_block_convolution
// Non-causal FIR filter over finite sample blocks, built from a row of cells.
// ----------------------------------------------------------------------------
// One item at a time: the input is ready only in the idle state. A tap load,
// or a sample that emits nothing, is taken without leaving the idle state. A
// sample that emits results is loaded into the cell row, which is then slid
// by 16 - f cells so the output sample sits at the center cell (f = delay of
// the first output); each result then passes a start state, the cell product
// register, the three-stage adder tree, the output state and output stalls.
module two_sided_block_convolution (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bcv_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bcv_pkg::CFG_W-1:0]         cfg_data_i,
  bcv_in_if.sink                            in_ch,
  bcv_out_if.source                         out_ch
);

  localparam int N  = bcv_pkg::NUM_CELLS;
  localparam int NC = bcv_pkg::NUM_CAUSAL;
  localparam int NA = bcv_pkg::NUM_ANTI;
  localparam int CW = bcv_pkg::CNT_W;

  bcv_pkg::state_e     state_q, state_d;
  logic [CW-1:0]       causal_used_q, anti_used_q;
  logic                sym_cfg_q;
  bcv_pkg::sample_t    window_q [N];
  bcv_pkg::sample_t    hp_q [NC];
  bcv_pkg::sample_t    hn_q [NA];
  logic [CW-1:0]       seen_q;
  logic [CW-1:0]       p_q, q_q, cnt_q, pre_q;
  logic [CW-1:0]       p_d, q_d, cnt_d, pre_d, f_d;
  logic                sym_q, last_q;
  logic                in_acc, out_acc, is_sample, emit_start;
  bcv_pkg::cell_ctrl_t ctrl;
  bcv_pkg::sample_t    cell_s [N];
  bcv_pkg::prod_t      prod [N];
  logic                sum_vld;

  assign in_ch.ready = (state_q == bcv_pkg::S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = (state_q == bcv_pkg::S_OUT);
  assign out_acc     = out_ch.valid && out_ch.ready;
  assign out_ch.final_output = last_q && (cnt_q == CW'(1));
  assign is_sample   = (bcv_pkg::kind_e'(in_ch.kind) == bcv_pkg::KIND_SAMPLE);

  always_comb begin
    p_d = (causal_used_q > CW'(NC)) ? CW'(NC) : causal_used_q;
    if (sym_cfg_q) begin
      q_d = (p_d != '0) ? p_d - CW'(1) : '0;
    end else begin
      q_d = (anti_used_q > CW'(NA)) ? CW'(NA) : anti_used_q;
    end
    if (seen_q >= q_d) begin
      cnt_d = in_ch.block_end ? q_d + CW'(1) : CW'(1);
      f_d   = q_d;
    end else begin
      cnt_d = in_ch.block_end ? seen_q + CW'(1) : '0;
      f_d   = seen_q;
    end
    pre_d = CW'(NA) - f_d;
  end

  assign emit_start = in_acc && is_sample && (cnt_d != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      causal_used_q <= CW'(1);
      anti_used_q   <= '0;
      sym_cfg_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (bcv_pkg::reg_idx_e'(cfg_idx_i))
        bcv_pkg::REG_CAUSAL_USED: causal_used_q <= cfg_data_i;
        bcv_pkg::REG_ANTI_USED:   anti_used_q   <= cfg_data_i;
        bcv_pkg::REG_SYMMETRIC:   sym_cfg_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // tap stores
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      case (bcv_pkg::kind_e'(in_ch.kind))
        bcv_pkg::KIND_CAUSAL: hp_q[in_ch.tap_index] <= in_ch.value;
        bcv_pkg::KIND_ANTI:   hn_q[in_ch.tap_index] <= in_ch.value;
        default: ;
      endcase
    end
  end

  // sample window and block bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) window_q[i] <= '0;
      seen_q <= '0;
      p_q    <= '0;
      q_q    <= '0;
      cnt_q  <= '0;
      pre_q  <= '0;
      sym_q  <= 1'b0;
      last_q <= 1'b0;
    end else begin
      if (in_acc && is_sample) begin
        for (int i = N - 1; i > 0; i--) window_q[i] <= window_q[i-1];
        window_q[0] <= in_ch.value;
        if (in_ch.block_end) begin
          seen_q <= '0;
        end else if (seen_q < bcv_pkg::SEEN_LIMIT) begin
          seen_q <= seen_q + CW'(1);
        end
      end
      if (emit_start) begin
        p_q    <= p_d;
        q_q    <= q_d;
        sym_q  <= sym_cfg_q;
        cnt_q  <= cnt_d;
        pre_q  <= pre_d;
        last_q <= in_ch.block_end;
      end
      if (state_q == bcv_pkg::S_LOAD && last_q) begin
        for (int i = 0; i < N; i++) window_q[i] <= '0;
      end
      if (state_q == bcv_pkg::S_PRESHIFT) begin
        pre_q <= pre_q - CW'(1);
      end
      if (out_acc) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bcv_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl.load  = 1'b0;
    ctrl.shift = 1'b0;
    case (state_q)
      bcv_pkg::S_IDLE: begin
        if (emit_start) state_d = bcv_pkg::S_LOAD;
      end
      bcv_pkg::S_LOAD: begin
        ctrl.load = 1'b1;
        state_d   = (pre_q != '0) ? bcv_pkg::S_PRESHIFT : bcv_pkg::S_START;
      end
      bcv_pkg::S_PRESHIFT: begin
        ctrl.shift = 1'b1;
        if (pre_q == CW'(1)) state_d = bcv_pkg::S_START;
      end
      bcv_pkg::S_START: begin
        state_d = bcv_pkg::S_WAIT;
      end
      bcv_pkg::S_WAIT: begin
        if (sum_vld) state_d = bcv_pkg::S_OUT;
      end
      bcv_pkg::S_OUT: begin
        if (out_acc) begin
          if (cnt_q == CW'(1)) begin
            state_d = bcv_pkg::S_IDLE;
          end else begin
            ctrl.shift = 1'b1;
            state_d    = bcv_pkg::S_START;
          end
        end
      end
      default: state_d = bcv_pkg::S_IDLE;
    endcase
  end

  // cell row: cell NA holds the output sample, higher cells causal, lower anticausal
  for (genvar i = 0; i < N; i++) begin : g_cell
    bcv_pkg::sample_t coef;
    logic             use_tap;
    bcv_pkg::sample_t prev;
    if (i >= NA) begin : g_causal
      assign coef    = hp_q[i-NA];
      assign use_tap = (CW'(i - NA) < p_q);
    end else if (NA - 1 - i + 1 < NC) begin : g_anti
      assign coef    = sym_q ? hp_q[NA-i] : hn_q[NA-1-i];
      assign use_tap = (CW'(NA - 1 - i) < q_q);
    end else begin : g_anti_last
      assign coef    = hn_q[NA-1-i];
      assign use_tap = (CW'(NA - 1 - i) < q_q);
    end
    if (i == 0) begin : g_head
      assign prev = '0;
    end else begin : g_link
      assign prev = cell_s[i-1];
    end
    bcv_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .load_val_i (window_q[i]),
      .prev_i     (prev),
      .coef_i     (coef),
      .use_i      (use_tap),
      .sample_o   (cell_s[i]),
      .prod_o     (prod[i])
    );
  end

  bcv_sum u_sum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (state_q == bcv_pkg::S_START),
    .prod_i   (prod),
    .valid_o  (sum_vld),
    .result_o (out_ch.filtered)
  );

endmodule

### sv/bcv_checker.sv
// ----------------------------------------------------------------------------
// bcv_checker
// Port-level checks of the filter's handshake sequencing.
// ----------------------------------------------------------------------------
module bcv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  in_kind_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_final_i,
  input logic [31:0] out_filtered_i
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_filtered_i)
      && $stable(out_final_i))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input taken while a result is pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_final_i |=> !out_valid_i)
    else $error("result after final output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_kind_i != bcv_pkg::KIND_SAMPLE |=> in_ready_i && !out_valid_i)
    else $error("tap load produced work");

endmodule

bind two_sided_block_convolution bcv_checker u_bcv_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_ch.valid),
  .in_ready_i     (in_ch.ready),
  .in_kind_i      (in_ch.kind),
  .out_valid_i    (out_ch.valid),
  .out_ready_i    (out_ch.ready),
  .out_final_i    (out_ch.final_output),
  .out_filtered_i (out_ch.filtered)
);
